### design/set_assoc_lru_cache_model_macros.svh
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SALC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SALC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/salc_pkg.sv
// Types, constants and defaults for the set-associative LRU cache model.
package salc_pkg;

  localparam int DEF_MAX_SET_BITS  = 6;
  localparam int DEF_MAX_WAYS      = 8;
  localparam int DEF_ADDRESS_WIDTH = 64;

  localparam int BLOCK_BITS_MAX = 32;
  localparam int COUNT_W        = 32;
  localparam int STAMP_W        = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EVAL,
    B_WRITE
  } back_state_t;

endpackage

### design/salc_ram.sv
// Generic simple dual-port RAM with registered read.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/salc_queue.sv
// Short item queue between the front and back parts.
`include "set_assoc_lru_cache_model_macros.svh"

module salc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  `SALC_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full || pop)
  `SALC_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !empty)

endmodule

### design/salc_front.sv
// Front part: configuration registers, item intake and set/tag split.
module salc_front #(
  parameter int MAX_SET_BITS  = 6,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64,
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1),
  localparam int ENTRY_W   = 2 + SET_W + ADDRESS_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             start,
  input  salc_pkg::opcode_t                opcode,
  input  logic [ADDRESS_WIDTH-1:0]         address,
  input  logic                             q_full,
  input  logic                             clearing,
  output logic                             busy,
  output logic                             push,
  output logic [ENTRY_W-1:0]               entry,
  output logic [WAY_CNT_W-1:0]             ways
);
  import salc_pkg::*;

  logic [2:0]               set_bits;
  logic [5:0]               block_bits;
  logic [3:0]               ways_in_use;
  logic [2:0]               s_eff;
  logic [5:0]               b_eff;
  logic [SET_W-1:0]         set_mask;
  logic [ADDRESS_WIDTH-1:0] shifted;
  logic [SET_W-1:0]         set_idx;
  logic [ADDRESS_WIDTH-1:0] tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd0;
      block_bits  <= 6'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_SET_BITS:    set_bits    <= cfg_data[2:0];
        REG_BLOCK_BITS:  block_bits  <= cfg_data[5:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff    = (int'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
    b_eff    = (int'(block_bits) > BLOCK_BITS_MAX) ? 6'(BLOCK_BITS_MAX) : block_bits;
    set_mask = ~({SET_W{1'b1}} << s_eff);
    shifted  = address >> b_eff;
    set_idx  = shifted[SET_W-1:0] & set_mask;
    tag      = address >> (7'(b_eff) + 7'(s_eff));
    if (ways_in_use == 4'd0) begin
      ways = WAY_CNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways = WAY_CNT_W'(ways_in_use);
    end
  end

  assign busy  = clearing | q_full;
  assign push  = start & ~busy;
  assign entry = {opcode, set_idx, tag};

endmodule

### design/salc_back.sv
// Back part: per-set read-modify-write lookup, LRU victim choice and counters.
`include "set_assoc_lru_cache_model_macros.svh"

module salc_back #(
  parameter int MAX_SET_BITS  = 6,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64,
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1),
  localparam int ENTRY_W   = 2 + SET_W + ADDRESS_WIDTH,
  localparam int ENT_W     = 1 + ADDRESS_WIDTH + salc_pkg::STAMP_W,
  localparam int ROW_W     = MAX_WAYS * ENT_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [WAY_CNT_W-1:0]            ways,
  input  logic                            q_empty,
  input  logic [ENTRY_W-1:0]              q_head,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            rd_en,
  output logic [SET_W-1:0]                rd_addr,
  input  logic [ROW_W-1:0]                rd_data,
  output logic                            wr_en,
  output logic [SET_W-1:0]                wr_addr,
  output logic [ROW_W-1:0]                wr_data,
  output logic                            done,
  output logic                            first_hit,
  output logic                            first_evicted,
  output logic                            second_done,
  output logic                            second_hit,
  output logic [salc_pkg::COUNT_W-1:0]    total_hits,
  output logic [salc_pkg::COUNT_W-1:0]    total_misses,
  output logic [salc_pkg::COUNT_W-1:0]    total_evictions
);
  import salc_pkg::*;

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_N = 2 ** WAY_W;
  localparam logic [SET_W-1:0] LAST_ROW = SET_W'((2 ** MAX_SET_BITS) - 1);

  back_state_t state, state_next;
  logic [SET_W-1:0]         clr_idx, clr_idx_next;
  logic [STAMP_W-1:0]       access_clock, access_clock_next;
  logic [COUNT_W-1:0]       hits_next, misses_next, evicts_next;
  logic                     done_next;
  logic                     fh_next, fe_next, sd_next, sh_next;

  opcode_t                  cur_op;
  logic [SET_W-1:0]         cur_set;
  logic [ADDRESS_WIDTH-1:0] cur_tag;
  logic                     load_cur;
  logic                     ev_hit, ev_evict;
  logic [WAY_W-1:0]         ev_way;

  opcode_t                  head_op;
  logic [SET_W-1:0]         head_set;
  logic [ADDRESS_WIDTH-1:0] head_tag;

  logic                     eval_found, eval_hit;
  logic [WAY_W-1:0]         eval_way;
  logic [STAMP_W:0]         key  [TREE_N];
  logic [WAY_W-1:0]         kidx [TREE_N];

  logic                     is_mod;
  logic [STAMP_W-1:0]       new_stamp;
  logic [ROW_W-1:0]         upd_row;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
                                                 input logic [1:0] inc);
    logic [COUNT_W:0] sum;
    sum = {1'b0, v} + (COUNT_W + 1)'(inc);
    return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  endfunction

  assign head_op  = opcode_t'(q_head[ENTRY_W-1 -: 2]);
  assign head_set = q_head[ADDRESS_WIDTH +: SET_W];
  assign head_tag = q_head[ADDRESS_WIDTH-1:0];

  // Scan: first in-use way that is empty or matches; else LRU by stamp tree.
  always_comb begin
    logic                     v;
    logic [ADDRESS_WIDTH-1:0] t;
    logic                     in_use;
    eval_found = 1'b0;
    eval_hit   = 1'b0;
    eval_way   = '0;
    for (int w = 0; w < TREE_N; w++) begin
      key[w]  = '1;
      kidx[w] = WAY_W'(w);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      v      = rd_data[w*ENT_W + ENT_W - 1];
      t      = rd_data[w*ENT_W + STAMP_W +: ADDRESS_WIDTH];
      in_use = (WAY_CNT_W'(w) < ways);
      key[w] = {~in_use, rd_data[w*ENT_W +: STAMP_W]};
      if (in_use && (!v || t == cur_tag)) begin
        eval_found = 1'b1;
        eval_hit   = v;
        eval_way   = WAY_W'(w);
      end
    end
    // ties keep the lower way
    for (int lv = 0; lv < WAY_W; lv++) begin
      for (int i = 0; i < (TREE_N >> (lv + 1)); i++) begin
        if (key[2*i+1] < key[2*i]) begin
          key[i]  = key[2*i+1];
          kidx[i] = kidx[2*i+1];
        end else begin
          key[i]  = key[2*i];
          kidx[i] = kidx[2*i];
        end
      end
    end
    if (!eval_found) begin
      eval_way = kidx[0];
    end
  end

  // A modify's second lookup always hits the way the first one left.
  assign is_mod    = (cur_op == OP_MODIFY);
  assign new_stamp = access_clock + (is_mod ? STAMP_W'(2) : STAMP_W'(1));

  always_comb begin
    upd_row = rd_data;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == ev_way) begin
        upd_row[w*ENT_W +: ENT_W] = {1'b1, cur_tag, new_stamp};
      end
    end
  end

  always_comb begin
    state_next        = state;
    clr_idx_next      = clr_idx;
    access_clock_next = access_clock;
    hits_next         = total_hits;
    misses_next       = total_misses;
    evicts_next       = total_evictions;
    done_next         = 1'b0;
    fh_next           = first_hit;
    fe_next           = first_evicted;
    sd_next           = second_done;
    sh_next           = second_hit;
    q_pop             = 1'b0;
    load_cur          = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = head_set;
    wr_en             = 1'b0;
    wr_addr           = cur_set;
    wr_data           = upd_row;
    case (state)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
        if (clr_idx == LAST_ROW) begin
          state_next = B_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          load_cur = 1'b1;
          if (head_op == OP_FETCH) begin
            done_next = 1'b1;
            fh_next   = 1'b0;
            fe_next   = 1'b0;
            sd_next   = 1'b0;
            sh_next   = 1'b0;
          end else begin
            rd_en      = 1'b1;
            state_next = B_EVAL;
          end
        end
      end
      B_EVAL: begin
        state_next = B_WRITE;
      end
      B_WRITE: begin
        wr_en             = 1'b1;
        done_next         = 1'b1;
        fh_next           = ev_hit;
        fe_next           = ev_evict;
        sd_next           = is_mod;
        sh_next           = is_mod;
        access_clock_next = new_stamp;
        hits_next   = sat_add(total_hits, {1'b0, ev_hit} + {1'b0, is_mod});
        misses_next = sat_add(total_misses, {1'b0, ~ev_hit});
        evicts_next = sat_add(total_evictions, {1'b0, ev_evict});
        state_next  = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_CLEAR;
      clr_idx         <= '0;
      access_clock    <= '0;
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      clr_idx         <= clr_idx_next;
      access_clock    <= access_clock_next;
      total_hits      <= hits_next;
      total_misses    <= misses_next;
      total_evictions <= evicts_next;
      done            <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    first_hit     <= fh_next;
    first_evicted <= fe_next;
    second_done   <= sd_next;
    second_hit    <= sh_next;
    if (load_cur) begin
      cur_op  <= head_op;
      cur_set <= head_set;
      cur_tag <= head_tag;
    end
    if (state == B_EVAL) begin
      ev_hit   <= eval_hit;
      ev_evict <= !eval_found;
      ev_way   <= eval_way;
    end
  end

  assign clearing = (state == B_CLEAR);

  `SALC_ASSERT_NEXT(a_eval_then_write, clk, rst, state == B_EVAL, state == B_WRITE)
  `SALC_ASSERT_NEXT(a_write_gives_item, clk, rst, state == B_WRITE, done)
  `SALC_ASSERT_IMPL(a_second_always_hits, clk, rst, done && second_done, second_hit)
  `SALC_ASSERT_IMPL(a_hit_not_evicted, clk, rst, done && first_hit, !first_evicted)

endmodule

### design/set_assoc_lru_cache_model.sv
// Set-associative LRU cache model: load/store/modify pass through the back part's
// set row read, tag scan and LRU tree, and row write states; a fetch ends at its pop.
// Strobe done is registered, rising after a fetch's pop or a lookup's row write.
// The back part pops no new item until a lookup's row write is done; a 2-entry queue
// lets start run ahead. After rst the set memory is cleared one row a cycle, all
// 2**MAX_SET_BITS rows (64 by default) with busy high; results have no backpressure.
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS  = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS      = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDRESS_WIDTH = salc_pkg::DEF_ADDRESS_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  salc_pkg::opcode_t               opcode,
  input  logic [ADDRESS_WIDTH-1:0]        address,
  output logic                            done,
  output logic                            first_hit,
  output logic                            first_evicted,
  output logic                            second_done,
  output logic                            second_hit,
  output logic [salc_pkg::COUNT_W-1:0]    total_hits,
  output logic [salc_pkg::COUNT_W-1:0]    total_misses,
  output logic [salc_pkg::COUNT_W-1:0]    total_evictions
);
  import salc_pkg::*;

  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int ENTRY_W   = 2 + SET_W + ADDRESS_WIDTH;
  localparam int ROW_W     = MAX_WAYS * (1 + ADDRESS_WIDTH + STAMP_W);

  logic                 push, pop, q_full, q_empty, clearing;
  logic [ENTRY_W-1:0]   entry, q_head;
  logic [WAY_CNT_W-1:0] ways;
  logic                 rd_en, wr_en;
  logic [SET_W-1:0]     rd_addr, wr_addr;
  logic [ROW_W-1:0]     rd_data, wr_data;

  salc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg_en  (cfg_en),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .start   (start),
    .opcode  (opcode),
    .address (address),
    .q_full  (q_full),
    .clearing(clearing),
    .busy    (busy),
    .push    (push),
    .entry   (entry),
    .ways    (ways)
  );

  salc_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(entry),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(2 ** MAX_SET_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  salc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .ways           (ways),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (pop),
    .clearing       (clearing),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .done           (done),
    .first_hit      (first_hit),
    .first_evicted  (first_evicted),
    .second_done    (second_done),
    .second_hit     (second_hit),
    .total_hits     (total_hits),
    .total_misses   (total_misses),
    .total_evictions(total_evictions)
  );

endmodule

### tb/set_assoc_lru_cache_model_tb.sv
// Self-checking testbench for the set-associative LRU cache model.
`timescale 1ns / 100ps

module set_assoc_lru_cache_model_tb;
  import salc_pkg::*;

  localparam int MAX_SET_BITS    = DEF_MAX_SET_BITS;
  localparam int MAX_WAYS        = DEF_MAX_WAYS;
  localparam int LINES           = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int RANDOM_PHASES   = 6;
  localparam int DRAIN_CYCLES    = 20;

  // index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        first_hit;
    logic        first_evicted;
    logic        second_done;
    logic        second_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } outcome_t;

  // Tracks the cache contents and counters, and holds the outcomes still due.
  class cache_tracker;
    bit              line_valid[LINES];
    bit [63:0]       line_tag[LINES];
    bit [31:0]       line_stamp[LINES];
    bit [31:0]       stamp_clock;
    bit [31:0]       hit_cnt;
    bit [31:0]       miss_cnt;
    bit [31:0]       evict_cnt;
    bit [2:0]        set_bits_r;
    bit [5:0]        block_bits_r;
    bit [3:0]        ways_r;
    outcome_t        pending[$];
    int              mismatches;

    function new();
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      stamp_clock  = '0;
      hit_cnt      = '0;
      miss_cnt     = '0;
      evict_cnt    = '0;
      set_bits_r   = 3'd0;
      block_bits_r = 6'd4;
      ways_r       = 4'd1;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SET_BITS:    set_bits_r = val[2:0];
        REG_BLOCK_BITS:  block_bits_r = val;
        REG_WAYS_IN_USE: ways_r = val[3:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] sat_inc(bit [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    // one cache lookup; returns hit
    function bit lookup(bit [63:0] a, output bit evicted);
      int unsigned s, b, ways, set_idx, base, victim, i, w;
      bit [63:0]   tag;
      bit          have_victim;
      s = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
      b = (block_bits_r > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_r;
      ways = ways_r;
      if (ways < 1) ways = 1;
      if (ways > MAX_WAYS) ways = MAX_WAYS;
      stamp_clock = stamp_clock + 32'd1;
      set_idx = int'((a >> b) & ((64'd1 << s) - 64'd1));
      tag = a >> (b + s);
      base = set_idx * MAX_WAYS;
      evicted = 1'b0;
      have_victim = 1'b0;
      victim = 0;
      for (w = 0; w < ways; w++) begin
        i = base + w;
        if (!line_valid[i]) begin
          miss_cnt = sat_inc(miss_cnt);
          line_valid[i] = 1'b1;
          line_tag[i] = tag;
          line_stamp[i] = stamp_clock;
          return 1'b0;
        end
        if (line_tag[i] == tag) begin
          hit_cnt = sat_inc(hit_cnt);
          line_stamp[i] = stamp_clock;
          return 1'b1;
        end
        if (!have_victim || line_stamp[i] < line_stamp[base + victim]) begin
          victim = w;
          have_victim = 1'b1;
        end
      end
      miss_cnt = sat_inc(miss_cnt);
      evict_cnt = sat_inc(evict_cnt);
      line_tag[base + victim] = tag;
      line_stamp[base + victim] = stamp_clock;
      evicted = 1'b1;
      return 1'b0;
    endfunction

    function void note_access(opcode_t op, bit [63:0] addr);
      outcome_t o;
      bit       ev1, ev2;
      o = '0;
      if (op != OP_FETCH) begin
        o.first_hit = lookup(addr, ev1);
        o.first_evicted = ev1;
        if (op == OP_MODIFY) begin
          o.second_done = 1'b1;
          o.second_hit = lookup(addr, ev2);
        end
      end
      o.hits = hit_cnt;
      o.misses = miss_cnt;
      o.evictions = evict_cnt;
      pending.push_back(o);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no access pending, expected none actual hits %0h",
                 $time, got.hits);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare("first_hit", want.first_hit, got.first_hit);
      compare("first_evicted", want.first_evicted, got.first_evicted);
      compare("second_done", want.second_done, got.second_done);
      compare("second_hit", want.second_hit, got.second_hit);
      compare("total_hits", want.hits, got.hits);
      compare("total_misses", want.misses, got.misses);
      compare("total_evictions", want.evictions, got.evictions);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  opcode_t               opcode;
  logic [63:0]           address;
  logic                  done;
  logic                  first_hit;
  logic                  first_evicted;
  logic                  second_done;
  logic                  second_hit;
  logic [COUNT_W-1:0]    total_hits;
  logic [COUNT_W-1:0]    total_misses;
  logic [COUNT_W-1:0]    total_evictions;

  cache_tracker tracker = new();

  bit [63:0] tag_pool[16];
  int        pool_n;
  int        quiet_cycles = 0;

  set_assoc_lru_cache_model i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_en          (cfg_en),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .address         (address),
    .done            (done),
    .first_hit       (first_hit),
    .first_evicted   (first_evicted),
    .second_done     (second_done),
    .second_hit      (second_hit),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    outcome_t got;
    if (!rst && done) begin
      got.first_hit     = first_hit;
      got.first_evicted = first_evicted;
      got.second_done   = second_done;
      got.second_hit    = second_hit;
      got.hits          = total_hits;
      got.misses        = total_misses;
      got.evictions     = total_evictions;
      tracker.check_outcome(got);
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("set_assoc_lru_cache_model_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high after acceptance so back-to-back items need no extra edge
  task automatic send_access(input opcode_t op, input logic [63:0] addr, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    opcode  <= op;
    address <= addr;
    do @(posedge clk); while (busy);
    tracker.note_access(op, addr);
  endtask

  // drop start and wait until every outcome is in and the block is idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic write_config(input logic [5:0] sb, input logic [5:0] bb, input logic [5:0] wy);
    put_reg(REG_SET_BITS, sb);
    put_reg(REG_BLOCK_BITS, bb);
    put_reg(REG_WAYS_IN_USE, wy);
    put_reg(REG_UNUSED, 6'($urandom));
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  function automatic opcode_t pick_opcode();
    if ($urandom_range(0, 9) == 0) return OP_FETCH;
    return opcode_t'($urandom_range(1, 3));
  endfunction

  // mostly addresses built from a small tag pool and few sets so lines collide
  function automatic logic [63:0] pick_address(int s, int b);
    bit [63:0] tag, set_idx, offset;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    tag = tag_pool[$urandom_range(0, pool_n - 1)];
    if ($urandom_range(0, 3) == 0) set_idx = 64'($urandom);
    else set_idx = 64'($urandom_range(0, 3));
    set_idx = set_idx & ((64'd1 << s) - 64'd1);
    offset = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
    return (tag << (b + s)) | (set_idx << b) | offset;
  endfunction

  initial begin
    logic [2:0] sb;
    logic [5:0] bb;
    logic [3:0] wy;
    int         s_eff, b_eff, w_eff, gap, burst_left;

    rst      = 1'b1;
    cfg_en   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    start    = 1'b0;
    opcode   = OP_FETCH;
    address  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    settle();

    // reset config: one way, 16-byte blocks, a single set
    send_access(OP_FETCH, 64'h0, 0);
    send_access(OP_LOAD, 64'h0, 0);
    send_access(OP_LOAD, 64'hF, 0);
    send_access(OP_STORE, 64'h10, 0);
    send_access(OP_MODIFY, 64'h10, 0);
    send_access(OP_MODIFY, 64'h20, 0);
    send_access(OP_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1);

    // two sets, two ways, no offset: fill, refresh, evict the older way
    settle();
    write_config(6'd1, 6'd0, 6'd2);
    send_access(OP_LOAD, 64'h0, 0);
    send_access(OP_LOAD, 64'h2, 0);
    send_access(OP_LOAD, 64'h0, 0);
    send_access(OP_LOAD, 64'h4, 0);
    send_access(OP_LOAD, 64'h2, 0);
    send_access(OP_STORE, 64'h4, 0);
    send_access(OP_MODIFY, 64'h6, 0);

    // out-of-range values clamp to the maximum
    settle();
    write_config(6'd7, 6'd63, 6'd15);
    send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_access(OP_LOAD, 64'hFFFF_FFFF_0000_0000, 0);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0000, 0);
    send_access(OP_STORE, 64'h0000_0000_FFFF_FFFF, 0);
    send_access(OP_LOAD, 64'h2, 2);

    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin sb = 3'd0; bb = 6'd0;  wy = 4'd1;  end
        1: begin sb = 3'd6; bb = 6'd32; wy = 4'd8;  end
        2: begin sb = 3'd7; bb = 6'd63; wy = 4'd15; end
        3: begin sb = 3'd3; bb = 6'd5;  wy = 4'd0;  end
        default: begin
          sb = 3'($urandom_range(0, 7));
          bb = 6'($urandom_range(0, 63));
          wy = 4'($urandom_range(0, 15));
        end
      endcase
      s_eff = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
      b_eff = (bb > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : bb;
      w_eff = (wy == 0) ? 1 : ((wy > MAX_WAYS) ? MAX_WAYS : wy);
      settle();
      // unused upper data bits go random
      write_config({3'($urandom), sb}, bb, {2'($urandom), wy});
      pool_n = w_eff + 3;
      for (int k = 0; k < pool_n; k++) tag_pool[k] = {$urandom, $urandom};

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 40) settle();
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(10, 30);
          gap = 0;
        end else begin
          gap = $urandom_range(0, 5);
        end
        send_access(pick_opcode(), pick_address(s_eff, b_eff), gap);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("set_assoc_lru_cache_model_tb passed");
    end else begin
      $display("set_assoc_lru_cache_model_tb failed");
    end
    $finish;
  end

endmodule
